### design/ocp_pkg.sv
// ----------------------------------------------------------------------------
// ocp_pkg
// Shared types and constants of the orbit camera position unit.
// ----------------------------------------------------------------------------
package ocp_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 23;
	localparam int DIST_W     = 23;
	localparam int STEP_W     = 12;
	localparam int PLIM_W     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIST = 2'd0,
		REG_STEP = 2'd1,
		REG_PMIN = 2'd2,
		REG_PMAX = 2'd3
	} ocp_reg_t;

	localparam logic [DIST_W-1:0]        DIST_RST = 23'd38400;
	localparam logic [STEP_W-1:0]        STEP_RST = 12'd313;
	localparam logic signed [PLIM_W-1:0] PMIN_RST = 16'sd0;
	localparam logic signed [PLIM_W-1:0] PMAX_RST = 16'sd12288;

	typedef struct packed {
		logic [DIST_W-1:0]        orbit_dist;
		logic [STEP_W-1:0]        step;
		logic signed [PLIM_W-1:0] pmin;
		logic signed [PLIM_W-1:0] pmax;
	} ocp_cfg_t;

	// CORDIC datapath: Q2.30 results, angles in 1/2^32 turn
	localparam int TRIG_W     = 32;
	localparam int CORDIC_W   = 34;
	localparam int ATAN_DEPTH = 24;
	localparam int ATAN_IW    = 5;

	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [31:0] ATAN_TURN [ATAN_DEPTH] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	typedef struct packed {
		logic                     done;
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} ocp_trig_t;

	// shared multiplier: 25-bit signed by 32-bit signed
	localparam int MUL_A_W   = 25;
	localparam int PROD_W    = MUL_A_W + TRIG_W;
	localparam int RND_SHIFT = 30;
	localparam int TERM_W    = PROD_W - RND_SHIFT;
	localparam logic [PROD_W:0] RND_HALF = (PROD_W+1)'(1) << (RND_SHIFT - 1);

	localparam int QDEPTH = 2;

endpackage

### design/ocp_fifo.sv
// ----------------------------------------------------------------------------
// ocp_fifo
// Short request queue between the front and the back end.
// ----------------------------------------------------------------------------
module ocp_fifo import ocp_pkg::*; #(
	parameter int WIDTH = 88
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             q_full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             q_empty
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	logic [WIDTH-1:0] mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = (count_q == CNT_W'(QDEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### design/ocp_front.sv
// ----------------------------------------------------------------------------
// ocp_front
// Config registers, request intake and yaw/pitch update with pitch clamping and yaw wrap-around.
// ----------------------------------------------------------------------------
module ocp_front import ocp_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter int COORD_BITS = 24,
	localparam int ITEM_W    = 2 * ANGLE_BITS + 3 * COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	output ocp_cfg_t                     cfg,
	input  logic                         push,
	output logic                         full,
	input  logic                         key_up,
	input  logic                         key_down,
	input  logic                         key_left,
	input  logic                         key_right,
	input  logic signed [COORD_BITS-1:0] target_x,
	input  logic signed [COORD_BITS-1:0] target_y,
	input  logic signed [COORD_BITS-1:0] target_z,
	input  logic                         q_full,
	output logic                         q_push,
	output logic [ITEM_W-1:0]            q_data
);

	localparam int PW = ((ANGLE_BITS > PLIM_W) ? ANGLE_BITS : PLIM_W) + 2;
	localparam int YW = ANGLE_BITS + STEP_W;
	localparam logic [ANGLE_BITS-1:0] YAW_RST   = {1'b1, {(ANGLE_BITS-1){1'b0}}};
	localparam logic [ANGLE_BITS-1:0] PITCH_RST = ANGLE_BITS'(PMAX_RST);

	ocp_cfg_t                     cfg_q;
	logic [ANGLE_BITS-1:0]        yaw_q;
	logic signed [ANGLE_BITS-1:0] pitch_q;
	logic signed [PW-1:0]         step_s;
	logic signed [PW-1:0]         p_val;
	logic [YW-1:0]                y_val;
	logic [ANGLE_BITS-1:0]        yaw_next;
	logic [ANGLE_BITS-1:0]        pitch_next;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;
	assign full      = q_full;
	assign q_push    = push && !q_full;
	assign q_data    = {yaw_next, pitch_next, target_x, target_y, target_z};

	always_comb begin
		step_s = signed'(PW'(cfg_q.step));
		p_val  = PW'(pitch_q);
		if (key_up) begin
			p_val = p_val + step_s;
		end
		if (key_down) begin
			p_val = p_val - step_s;
		end
		if (p_val < PW'(cfg_q.pmin)) begin
			p_val = PW'(cfg_q.pmin);
		end
		if (p_val > PW'(cfg_q.pmax)) begin
			p_val = PW'(cfg_q.pmax);
		end
		pitch_next = p_val[ANGLE_BITS-1:0];

		y_val = YW'(yaw_q);
		if (key_left) begin
			y_val = y_val + YW'(cfg_q.step);
		end
		if (key_right) begin
			y_val = y_val - YW'(cfg_q.step);
		end
		yaw_next = y_val[ANGLE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.orbit_dist <= DIST_RST;
			cfg_q.step       <= STEP_RST;
			cfg_q.pmin       <= PMIN_RST;
			cfg_q.pmax       <= PMAX_RST;
			yaw_q            <= YAW_RST;
			pitch_q          <= PITCH_RST;
		end else begin
			if (cfg_valid) begin
				unique case (ocp_reg_t'(cfg_index))
					REG_DIST: cfg_q.orbit_dist <= cfg_data[DIST_W-1:0];
					REG_STEP: cfg_q.step <= cfg_data[STEP_W-1:0];
					REG_PMIN: cfg_q.pmin <= cfg_data[PLIM_W-1:0];
					REG_PMAX: cfg_q.pmax <= cfg_data[PLIM_W-1:0];
					default: ;
				endcase
			end
			if (q_push) begin
				yaw_q   <= yaw_next;
				pitch_q <= pitch_next;
			end
		end
	end

endmodule

### design/ocp_cordic.sv
// ----------------------------------------------------------------------------
// ocp_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ocp_cordic import ocp_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter int TRIG_STEPS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [ANGLE_BITS-1:0] angle,
	output ocp_trig_t             trig
);

	logic                       busy_q;
	logic                       done_q;
	logic                       flip_q;
	logic [ATAN_IW-1:0]         i_q;
	logic signed [CORDIC_W-1:0] x_q;
	logic signed [CORDIC_W-1:0] y_q;
	logic signed [CORDIC_W-1:0] z_q;
	logic [31:0]                a_turn;
	logic [31:0]                a_fold;
	logic                       flip;
	logic signed [CORDIC_W-1:0] x_sh;
	logic signed [CORDIC_W-1:0] y_sh;
	logic signed [CORDIC_W-1:0] atan_v;
	logic signed [CORDIC_W-1:0] x_out;
	logic signed [CORDIC_W-1:0] y_out;

	always_comb begin
		a_turn = {angle, {(32-ANGLE_BITS){1'b0}}};
		// fold into [-1/4, 1/4) turn with a half-turn flip
		flip   = a_turn[31] ^ a_turn[30];
		a_fold = {a_turn[31] ^ flip, a_turn[30:0]};
		x_sh   = x_q >>> i_q;
		y_sh   = y_q >>> i_q;
		atan_v = signed'(CORDIC_W'(ATAN_TURN[i_q]));
		x_out  = flip_q ? -x_q : x_q;
		y_out  = flip_q ? -y_q : y_q;
	end

	assign trig.done  = done_q;
	assign trig.cos_v = x_out[TRIG_W-1:0];
	assign trig.sin_v = y_out[TRIG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == ATAN_IW'(TRIG_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= CORDIC_W'(signed'(a_fold));
			flip_q <= flip;
		end else if (busy_q) begin
			if (!z_q[CORDIC_W-1]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + atan_v;
			end
		end
	end

endmodule

### design/ocp_back.sv
// ----------------------------------------------------------------------------
// ocp_back
// Sequencer: sine/cosine of pitch and yaw, four products on one multiplier,
// offset from target with saturation, result register.
// ----------------------------------------------------------------------------
module ocp_back import ocp_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter int COORD_BITS = 24,
	localparam int ITEM_W    = 2 * ANGLE_BITS + 3 * COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ocp_cfg_t                     cfg,
	input  logic                         q_empty,
	input  logic [ITEM_W-1:0]            q_data,
	output logic                         q_pop,
	output logic                         cord_start,
	output logic [ANGLE_BITS-1:0]        cord_angle,
	input  ocp_trig_t                    trig,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [COORD_BITS-1:0] camera_x,
	output logic signed [COORD_BITS-1:0] camera_y,
	output logic signed [COORD_BITS-1:0] camera_z
);

	localparam int SW = ((COORD_BITS > TERM_W) ? COORD_BITS : TERM_W) + 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PITCH,
		S_YAW,
		S_MUL_DC,
		S_MUL_DS,
		S_MUL_RS,
		S_MUL_RC,
		S_TERM,
		S_OUT
	} state_t;

	state_t                       state_q;
	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] cam_x_q;
	logic signed [COORD_BITS-1:0] cam_y_q;
	logic signed [COORD_BITS-1:0] cam_z_q;
	logic [ANGLE_BITS-1:0]        yaw_q;
	logic signed [COORD_BITS-1:0] tx_q;
	logic signed [COORD_BITS-1:0] ty_q;
	logic signed [COORD_BITS-1:0] tz_q;
	logic signed [TRIG_W-1:0]     cp_q;
	logic signed [TRIG_W-1:0]     sp_q;
	logic signed [TRIG_W-1:0]     cy_q;
	logic signed [TRIG_W-1:0]     sy_q;
	logic signed [PROD_W-1:0]     prod_q;
	logic signed [MUL_A_W-1:0]    r_q;
	logic signed [TERM_W-1:0]     x_term_q;
	logic signed [TERM_W-1:0]     y_term_q;
	logic signed [TERM_W-1:0]     z_term_q;
	logic signed [MUL_A_W-1:0]    d_ext;
	logic signed [MUL_A_W-1:0]    mul_a;
	logic signed [TRIG_W-1:0]     mul_b;
	logic signed [PROD_W-1:0]     prod_n;
	logic signed [TERM_W-1:0]     term_n;
	logic signed [SW-1:0]         x_sum;
	logic signed [SW-1:0]         y_sum;
	logic signed [SW-1:0]         z_sum;
	logic                         out_free;

	function automatic logic signed [TERM_W-1:0] round_term(
		input logic signed [PROD_W-1:0] p
	);
		logic [PROD_W:0] s;
		s = {p[PROD_W-1], p} + RND_HALF;
		return s[PROD_W-1:RND_SHIFT];
	endfunction

	function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [SW-1:0] v);
		logic ovf;
		ovf = (v[SW-1:COORD_BITS-1] != {(SW-COORD_BITS+1){v[SW-1]}});
		return ovf ? {v[SW-1], {(COORD_BITS-1){~v[SW-1]}}} : v[COORD_BITS-1:0];
	endfunction

	assign q_pop      = (state_q == S_IDLE) && !q_empty;
	assign cord_start = q_pop || ((state_q == S_PITCH) && trig.done);
	assign cord_angle = (state_q == S_IDLE) ? q_data[ITEM_W-ANGLE_BITS-1 -: ANGLE_BITS]
		: yaw_q;
	assign empty      = !out_valid_q;
	assign camera_x   = cam_x_q;
	assign camera_y   = cam_y_q;
	assign camera_z   = cam_z_q;
	assign out_free   = !out_valid_q || pop;

	always_comb begin
		d_ext = signed'(MUL_A_W'(cfg.orbit_dist));
		unique case (state_q)
			S_MUL_DC: begin
				mul_a = d_ext;
				mul_b = cp_q;
			end
			S_MUL_DS: begin
				mul_a = d_ext;
				mul_b = sp_q;
			end
			S_MUL_RS: begin
				mul_a = r_q;
				mul_b = sy_q;
			end
			default: begin
				mul_a = r_q;
				mul_b = cy_q;
			end
		endcase
		prod_n = mul_a * mul_b;
		term_n = round_term(prod_q);
		x_sum  = SW'(tx_q) - SW'(x_term_q);
		y_sum  = SW'(ty_q) - SW'(y_term_q);
		z_sum  = SW'(tz_q) + SW'(z_term_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= S_PITCH;
					end
				end
				S_PITCH: begin
					if (trig.done) begin
						state_q <= S_YAW;
					end
				end
				S_YAW: begin
					if (trig.done) begin
						state_q <= S_MUL_DC;
					end
				end
				S_MUL_DC: state_q <= S_MUL_DS;
				S_MUL_DS: state_q <= S_MUL_RS;
				S_MUL_RS: state_q <= S_MUL_RC;
				S_MUL_RC: state_q <= S_TERM;
				S_TERM:   state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			yaw_q <= q_data[ITEM_W-1 -: ANGLE_BITS];
			tx_q  <= q_data[3*COORD_BITS-1 -: COORD_BITS];
			ty_q  <= q_data[2*COORD_BITS-1 -: COORD_BITS];
			tz_q  <= q_data[COORD_BITS-1:0];
		end
		if (state_q == S_PITCH && trig.done) begin
			cp_q <= trig.cos_v;
			sp_q <= trig.sin_v;
		end
		if (state_q == S_YAW && trig.done) begin
			cy_q <= trig.cos_v;
			sy_q <= trig.sin_v;
		end
		prod_q <= prod_n;
		if (state_q == S_MUL_DS) begin
			r_q <= term_n[MUL_A_W-1:0];
		end
		if (state_q == S_MUL_RS) begin
			z_term_q <= term_n;
		end
		if (state_q == S_MUL_RC) begin
			x_term_q <= term_n;
		end
		if (state_q == S_TERM) begin
			y_term_q <= term_n;
		end
		if (state_q == S_OUT && out_free) begin
			cam_x_q <= sat_coord(x_sum);
			cam_y_q <= sat_coord(y_sum);
			cam_z_q <= sat_coord(z_sum);
		end
	end

endmodule

### design/orbit_camera_position_unit.sv
// ----------------------------------------------------------------------------
// orbit_camera_position_unit
// Orbit camera: keys steer yaw and pitch, output is the camera position
// around the target point.
// ----------------------------------------------------------------------------
// Each request carries four key bits and a target point; the front end applies
// the keys to yaw and pitch in the cycle the request is taken and queues it in
// a two-entry queue, so push is taken every cycle until that queue fills. The
// back end then takes the requests one at a time: one shared CORDIC runs
// TRIG_STEPS micro-rotations for pitch and then for yaw, and one 25x32
// multiplier forms the four products in turn. Results wait in an output
// register until popped while the back end starts on the next request.
// Config writes are always ready and take effect at once.
module orbit_camera_position_unit import ocp_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter int COORD_BITS = 24,
	parameter int TRIG_STEPS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         push,
	output logic                         full,
	input  logic                         key_up,
	input  logic                         key_down,
	input  logic                         key_left,
	input  logic                         key_right,
	input  logic signed [COORD_BITS-1:0] target_x,
	input  logic signed [COORD_BITS-1:0] target_y,
	input  logic signed [COORD_BITS-1:0] target_z,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [COORD_BITS-1:0] camera_x,
	output logic signed [COORD_BITS-1:0] camera_y,
	output logic signed [COORD_BITS-1:0] camera_z
);

	localparam int ITEM_W = 2 * ANGLE_BITS + 3 * COORD_BITS;

	ocp_cfg_t              cfg;
	ocp_trig_t             trig;
	logic                  q_full;
	logic                  q_empty;
	logic                  q_push;
	logic                  q_pop;
	logic [ITEM_W-1:0]     q_wr_data;
	logic [ITEM_W-1:0]     q_rd_data;
	logic                  cord_start;
	logic [ANGLE_BITS-1:0] cord_angle;

	ocp_front #(
		.ANGLE_BITS(ANGLE_BITS),
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.push      (push),
		.full      (full),
		.key_up    (key_up),
		.key_down  (key_down),
		.key_left  (key_left),
		.key_right (key_right),
		.target_x  (target_x),
		.target_y  (target_y),
		.target_z  (target_z),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wr_data)
	);

	ocp_fifo #(
		.WIDTH(ITEM_W)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_data),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.q_empty (q_empty)
	);

	ocp_cordic #(
		.ANGLE_BITS(ANGLE_BITS),
		.TRIG_STEPS(TRIG_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.angle  (cord_angle),
		.trig   (trig)
	);

	ocp_back #(
		.ANGLE_BITS(ANGLE_BITS),
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_empty    (q_empty),
		.q_data     (q_rd_data),
		.q_pop      (q_pop),
		.cord_start (cord_start),
		.cord_angle (cord_angle),
		.trig       (trig),
		.empty      (empty),
		.pop        (pop),
		.camera_x   (camera_x),
		.camera_y   (camera_y),
		.camera_z   (camera_z)
	);

endmodule

### design/ocp_checker.sv
// ----------------------------------------------------------------------------
// ocp_checker
// Port-level checks of the orbit camera position unit, bound to the top.
// ----------------------------------------------------------------------------
module ocp_checker #(
	parameter int COORD_BITS = 24
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  push,
	input logic                  full,
	input logic                  pop,
	input logic                  empty,
	input logic [COORD_BITS-1:0] camera_x,
	input logic [COORD_BITS-1:0] camera_y,
	input logic [COORD_BITS-1:0] camera_z
);

	// queue entries, one in the back end, one in the result register
	localparam logic [2:0] CAPACITY = 3'd4;

	logic [2:0] pend_q;
	logic       in_req;
	logic       out_req;

	assign in_req  = push && !full;
	assign out_req = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_req && !out_req) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_req && !in_req) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("outputs not idle during reset");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(camera_x) && $stable(camera_y)
			&& $stable(camera_z))
		else $error("waiting result changed or vanished");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != 3'd0)
		else $error("result shown with no request outstanding");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= CAPACITY)
		else $error("more requests outstanding than the unit can hold");

endmodule

bind orbit_camera_position_unit ocp_checker #(.COORD_BITS(COORD_BITS)) u_ocp_checker (.*);
